[rtl/gps_pkg.sv]
// Shared types, codes and helper functions for the gamepad poll sequencer.
// No dependencies. Every other file in the project uses this package.
package gps_pkg;

  localparam int unsigned FrameLast    = 8;
  localparam int unsigned StoreDepth   = 8;
  localparam int unsigned StoreIdxW    = $clog2(StoreDepth);
  localparam int unsigned MinOkBytes   = 4;

  localparam logic [7:0] AckTimeoutRst = 8'd100;
  localparam logic [7:0] ConfigId      = 8'hF3;
  localparam logic [7:0] IdDigital     = 8'h41;
  localparam logic [7:0] IdAnalog      = 8'h73;
  localparam logic [7:0] CmdHeader     = 8'h01;
  localparam logic [7:0] CmdPoll       = 8'h42;
  localparam logic [7:0] CmdConfig     = 8'h43;
  localparam logic [7:0] CmdAnalog     = 8'h44;
  localparam logic [7:0] AnalogLock    = 8'h02;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_ACK   = 2'd2,
    REQ_TICK  = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_POLL   = 2'd0,
    KIND_CONFIG = 2'd1,
    KIND_ANALOG = 2'd2,
    KIND_NONE   = 2'd3
  } cmd_kind_e;

  typedef enum logic [1:0] {
    PAD_DIGITAL = 2'd0,
    PAD_ANALOG  = 2'd1,
    PAD_UNKNOWN = 2'd2
  } pad_type_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] command_kind;
    logic       mode_flag;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic        select_active;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        frame_done;
    logic        frame_ok;
    logic [7:0]  pad_id;
    logic        in_config_mode;
    logic [1:0]  pad_type;
    logic [15:0] buttons;
    logic [15:0] r_stick_xy;
    logic [15:0] l_stick_xy;
  } rsp_t;

  // Command byte offered at a given frame position.
  function automatic logic [7:0] command_byte(input logic [3:0] pos,
                                              input logic [1:0] kind,
                                              input logic       flag);
    logic [7:0] b;
    b = 8'h00;
    case (pos)
      4'd0: b = CmdHeader;
      4'd1: begin
        if (kind == KIND_POLL)        b = CmdPoll;
        else if (kind == KIND_CONFIG) b = CmdConfig;
        else                          b = CmdAnalog;
      end
      4'd3: b = (kind == KIND_POLL) ? 8'h00 : {7'd0, flag};
      4'd4: b = (kind == KIND_ANALOG) ? AnalogLock : 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] pad_type_of(input logic [7:0] id);
    logic [1:0] t;
    if (id == IdDigital)     t = PAD_DIGITAL;
    else if (id == IdAnalog) t = PAD_ANALOG;
    else                     t = PAD_UNKNOWN;
    return t;
  endfunction

endpackage

[rtl/gps_if.sv]
// Valid/ready channel interfaces for the gamepad poll sequencer.
// Depends on gps_pkg for the payload types.
interface gps_req_if;
  logic          valid;
  logic          ready;
  gps_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gps_rsp_if;
  logic          valid;
  logic          ready;
  gps_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gps_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/gps_in_reg.sv]
// Input register stage: holds one request transaction until the core takes it.
// Depends on gps_pkg.
module gps_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  gps_pkg::req_t data_i,
  input  logic          take_i,
  output logic          valid_o,
  output gps_pkg::req_t data_o
);

  logic          valid_q;
  gps_pkg::req_t data_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

[rtl/gps_seq.sv]
// Frame sequencer: protocol state, reply store and next-result logic.
// Depends on gps_pkg. State advances on step_i, one request per cycle while step_i is high.
module gps_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  gps_pkg::req_t req_i,
  input  logic [7:0]    timeout_i,
  output gps_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = gps_pkg::StoreIdxW;

  logic        busy_q, busy_d;
  logic [3:0]  pos_q, pos_d;
  logic        wait_ack_q, wait_ack_d;
  logic        ack_seen_q, ack_seen_d;
  logic [7:0]  wait_cnt_q, wait_cnt_d;
  logic [1:0]  kind_q, kind_d;
  logic        flag_q, flag_d;
  logic [3:0]  count_q, count_d;
  logic [7:0]  id_q, id_d;
  logic        cfg_flag_q, cfg_flag_d;
  logic [15:0] buttons_q, buttons_d;
  logic [15:0] rstick_q, rstick_d;
  logic [15:0] lstick_q, lstick_d;

  logic [7:0]  store_q [gps_pkg::StoreDepth];
  logic [7:0]  store_n [gps_pkg::StoreDepth];
  logic        store_we;
  logic [IdxW-1:0] store_idx;

  logic        tx_valid, frame_done, frame_ok, end_frame, advance;
  logic [7:0]  tx_byte, limit;

  assign store_idx = pos_q[IdxW-1:0] - {{(IdxW-1){1'b0}}, 1'b1};
  assign limit     = (timeout_i == 8'd0) ? 8'd1 : timeout_i;

  // Store view with this transaction's byte already in place (last byte ends the frame).
  always_comb begin
    for (int i = 0; i < gps_pkg::StoreDepth; i++) begin
      store_n[i] = store_q[i];
    end
    if (store_we) begin
      store_n[store_idx] = req_i.rx_byte;
    end
  end

  always_comb begin
    busy_d     = busy_q;
    pos_d      = pos_q;
    wait_ack_d = wait_ack_q;
    ack_seen_d = ack_seen_q;
    wait_cnt_d = wait_cnt_q;
    kind_d     = kind_q;
    flag_d     = flag_q;
    count_d    = count_q;
    id_d       = id_q;
    cfg_flag_d = cfg_flag_q;
    buttons_d  = buttons_q;
    rstick_d   = rstick_q;
    lstick_d   = lstick_q;
    tx_valid   = 1'b0;
    tx_byte    = 8'h00;
    frame_done = 1'b0;
    frame_ok   = 1'b0;
    end_frame  = 1'b0;
    advance    = 1'b0;
    store_we   = 1'b0;

    case (req_i.req_type)
      gps_pkg::REQ_START: begin
        if (!busy_q && req_i.command_kind != gps_pkg::KIND_NONE) begin
          busy_d     = 1'b1;
          kind_d     = req_i.command_kind;
          flag_d     = req_i.mode_flag;
          pos_d      = 4'd0;
          count_d    = 4'd0;
          ack_seen_d = 1'b0;
          wait_ack_d = 1'b0;
          wait_cnt_d = 8'd0;
          tx_valid   = 1'b1;
          tx_byte    = gps_pkg::command_byte(4'd0, req_i.command_kind, req_i.mode_flag);
        end
      end
      gps_pkg::REQ_BYTE: begin
        if (busy_q && !wait_ack_q) begin
          if (pos_q != 4'd0 && pos_q <= 4'(gps_pkg::FrameLast)) begin
            store_we = 1'b1;
            count_d  = count_q + 4'd1;
          end
          if (pos_q >= 4'(gps_pkg::FrameLast)) begin
            end_frame = 1'b1;
          end else if (ack_seen_q) begin
            advance = 1'b1;
          end else begin
            wait_ack_d = 1'b1;
            wait_cnt_d = 8'd0;
          end
        end
      end
      gps_pkg::REQ_ACK: begin
        if (busy_q) begin
          if (wait_ack_q) advance = 1'b1;
          else            ack_seen_d = 1'b1;
        end
      end
      gps_pkg::REQ_TICK: begin
        if (busy_q && wait_ack_q) begin
          wait_cnt_d = wait_cnt_q + 8'd1;
          if (wait_cnt_d >= limit) end_frame = 1'b1;
        end
      end
      default: ;
    endcase

    if (advance) begin
      pos_d      = pos_q + 4'd1;
      ack_seen_d = 1'b0;
      wait_ack_d = 1'b0;
      wait_cnt_d = 8'd0;
      tx_valid   = 1'b1;
      tx_byte    = gps_pkg::command_byte(pos_d, kind_q, flag_q);
    end

    if (end_frame) begin
      frame_done = 1'b1;
      frame_ok   = (count_d >= 4'(gps_pkg::MinOkBytes));
      busy_d     = 1'b0;
      wait_ack_d = 1'b0;
      ack_seen_d = 1'b0;
      wait_cnt_d = 8'd0;
      if (frame_ok) begin
        if (store_n[0] == gps_pkg::ConfigId) begin
          cfg_flag_d = 1'b1;
        end else begin
          cfg_flag_d = 1'b0;
          id_d       = store_n[0];
        end
        if (kind_q == gps_pkg::KIND_POLL) begin
          buttons_d = ~{store_n[3], store_n[2]};
          if (count_d >= 4'(gps_pkg::FrameLast)) begin
            rstick_d = {store_n[5], store_n[4]};
            lstick_d = {store_n[7], store_n[6]};
          end else begin
            rstick_d = 16'h0000;
            lstick_d = 16'h0000;
          end
        end
      end
    end
  end

  always_comb begin
    rsp_o.select_active  = busy_d;
    rsp_o.tx_valid       = tx_valid;
    rsp_o.tx_byte        = tx_byte;
    rsp_o.frame_done     = frame_done;
    rsp_o.frame_ok       = frame_ok;
    rsp_o.pad_id         = id_d;
    rsp_o.in_config_mode = cfg_flag_d;
    rsp_o.pad_type       = gps_pkg::pad_type_of(id_d);
    rsp_o.buttons        = buttons_d;
    rsp_o.r_stick_xy     = rstick_d;
    rsp_o.l_stick_xy     = lstick_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pos_q      <= 4'd0;
      wait_ack_q <= 1'b0;
      ack_seen_q <= 1'b0;
      wait_cnt_q <= 8'd0;
      kind_q     <= 2'd0;
      flag_q     <= 1'b0;
      count_q    <= 4'd0;
      id_q       <= 8'd0;
      cfg_flag_q <= 1'b0;
      buttons_q  <= 16'd0;
      rstick_q   <= 16'd0;
      lstick_q   <= 16'd0;
    end else if (step_i) begin
      busy_q     <= busy_d;
      pos_q      <= pos_d;
      wait_ack_q <= wait_ack_d;
      ack_seen_q <= ack_seen_d;
      wait_cnt_q <= wait_cnt_d;
      kind_q     <= kind_d;
      flag_q     <= flag_d;
      count_q    <= count_d;
      id_q       <= id_d;
      cfg_flag_q <= cfg_flag_d;
      buttons_q  <= buttons_d;
      rstick_q   <= rstick_d;
      lstick_q   <= lstick_d;
    end
  end

  // Reply store: no reset, entries are only read once written.
  always_ff @(posedge clk_i) begin
    if (step_i && store_we) begin
      store_q[store_idx] <= req_i.rx_byte;
    end
  end

  a_wait_needs_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_ack_q |-> busy_q) else $error("waiting for ack outside a frame");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 4'(gps_pkg::FrameLast)) else $error("byte position past frame end");

  a_count_le_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pos_q) else $error("reply count ahead of byte position");

  a_done_releases : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && frame_done) |=> !busy_q) else $error("frame end did not release select");

endmodule

[rtl/gps_out_reg.sv]
// Result register stage: holds one response transaction until the sink takes it.
// Depends on gps_pkg.
module gps_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  gps_pkg::rsp_t data_i,
  output logic          can_load_o,
  output logic          valid_o,
  input  logic          ready_i,
  output gps_pkg::rsp_t data_o
);

  logic          valid_q;
  gps_pkg::rsp_t data_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      data_q <= data_i;
    end
  end

endmodule

[rtl/gamepad_poll_sequencer_core.sv]
// Top level of the gamepad poll sequencer.
// Depends on gps_pkg, gps_if, gps_in_reg, gps_seq and gps_out_reg.
//
// Usage:
//   req_i  - request transactions: start frame, byte exchanged, ack edge or
//            microsecond tick, each with its payload fields.
//   rsp_o  - exactly one response transaction per request: select line,
//            command byte to shift out, frame end/status and the latest pad
//            id, mode, buttons and stick values.
//   cfg_i  - write of the ack timeout in ticks (zero behaves as one). Always
//            ready; write only while no request is in flight.
// Path: a taken request waits in the input register, then one pass of sequencer
// logic computes its response into the result register.
// Throughput: one transaction per cycle unless stalled; the sequencer state loop
// is a single register stage, so back-to-back requests each see the prior one's effect.
// Reset: all control state clears, timeout returns to 100 ticks, pad id and
// report read as zero. The reply store is not cleared; it is only read after
// the frame has written it.
// Stall: while rsp_o is held, the result register keeps its transaction and
// the input register still takes one more request; after that req_i.ready drops.
module gamepad_poll_sequencer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  gps_req_if.sink    req_i,
  gps_rsp_if.source  rsp_o,
  gps_cfg_if.sink    cfg_i
);

  logic [7:0]    ack_timeout_q;
  logic          in_valid;
  gps_pkg::req_t in_data;
  gps_pkg::rsp_t seq_rsp;
  logic          out_can_load;
  logic          step;

  // Timeout register; writes always accepted.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= gps_pkg::AckTimeoutRst;
    end else if (cfg_i.valid) begin
      ack_timeout_q <= cfg_i.data;
    end
  end

  // A held request moves into the result register whenever that has room.
  assign step = in_valid && out_can_load;

  gps_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .data_i  (req_i.payload),
    .take_i  (out_can_load),
    .valid_o (in_valid),
    .data_o  (in_data)
  );

  gps_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .req_i     (in_data),
    .timeout_i (ack_timeout_q),
    .rsp_o     (seq_rsp)
  );

  gps_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_valid),
    .data_i     (seq_rsp),
    .can_load_o (out_can_load),
    .valid_o    (rsp_o.valid),
    .ready_i    (rsp_o.ready),
    .data_o     (rsp_o.payload)
  );

endmodule
